// ===== sv/rtop_pkg.sv =====
// Shared types, codes and helpers for the ranked table with a global offset.
// No dependencies; used by rtop_cell and ranked_table_offset_prune.
package rtop_pkg;

    localparam int KEY_W = 32;
    localparam int WIDE_W = KEY_W + 2;
    localparam int AMT_W = 20;
    localparam int OP_W = 2;
    localparam int ST_W = 3;
    localparam int VAL_W = 31;
    localparam int EVC_W = 32;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_RAISE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CUT    = 2'd2;
    localparam logic [OP_W-1:0] OP_RANK   = 2'd3;

    localparam logic [ST_W-1:0] ST_DONE     = 3'd0;
    localparam logic [ST_W-1:0] ST_VALID    = 3'd1;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [ST_W-1:0] ST_BELOW    = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic signed [WIDE_W-1:0] t_wide;

    // broadcast to every cell
    typedef struct packed {
        logic             ins_en;
        logic             kill_en;
        logic             rank_en;
        t_key             key;
        t_wide            thr;
        logic [AMT_W-1:0] rank;
    } t_cmd;

    // handed from a cell to its right-hand neighbour
    typedef struct packed {
        logic ge;
        logic valid;
        t_key key;
    } t_link;

    function automatic t_key sat_key(input t_wide x);
        t_key r;
        if (x[WIDE_W-1:KEY_W-1] == '0 || x[WIDE_W-1:KEY_W-1] == '1) begin
            r = x[KEY_W-1:0];
        end else if (x[WIDE_W-1]) begin
            r = {1'b1, {(KEY_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(KEY_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== sv/rtop_cell.sv =====
// One slot of the sorted chain: holds a key and its valid bit.
// Depends on rtop_pkg.
module rtop_cell #(
    parameter int IDX = 0,
    parameter int CNT_W = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rtop_pkg::t_cmd      i_cmd,
    input  rtop_pkg::t_link     i_left,
    input  logic                i_right_valid,
    output rtop_pkg::t_link     o_link,
    output rtop_pkg::t_key      o_rank_key,
    output logic [CNT_W-1:0]    o_bound
);

    rtop_pkg::t_key r_key;
    logic           r_valid;
    logic           w_ge;
    logic           w_kill;
    rtop_pkg::t_wide w_key_wide;

    assign w_key_wide = {{2{r_key[rtop_pkg::KEY_W-1]}}, r_key};
    assign w_ge   = r_valid && ($signed(r_key) >= $signed(i_cmd.key));
    assign w_kill = r_valid && ($signed(w_key_wide) < $signed(i_cmd.thr));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.ins_en && !w_ge) begin
            r_valid <= i_left.ge ? 1'b1 : i_left.valid;
        end else if (i_cmd.kill_en && w_kill) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_en && !w_ge) begin
            r_key <= i_left.ge ? i_cmd.key : i_left.key;
        end
    end

    assign o_link = '{ge: w_ge, valid: r_valid, key: r_key};
    assign o_rank_key = (i_cmd.rank_en && r_valid &&
                         i_cmd.rank == rtop_pkg::AMT_W'(IDX + 1)) ? r_key : '0;
    assign o_bound = (r_valid && !i_right_valid) ? CNT_W'(IDX + 1) : '0;

endmodule

// ===== sv/ranked_table_offset_prune.sv =====
// Ranked table with a lazy global offset: top level, control and counters.
// A beat passes the execute and settle states; o_valid then rises from a register.
// A new beat can be accepted in the settle state; busy is high for the one cycle in
// which the cell chain inserts, evicts or selects, then the count settles.
// Reset (synchronous, active low) empties the table and clears offset,
// eviction total and minimum. The receiver cannot stall; o_valid is a one-cycle strobe.
module ranked_table_offset_prune #(
    parameter int CAPACITY = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [rtop_pkg::OP_W-1:0]       i_opcode,
    input  logic [rtop_pkg::AMT_W-1:0]      i_amount,
    input  logic                            i_cfg_we,
    input  logic [rtop_pkg::AMT_W-1:0]      i_cfg_wdata,
    output logic                            o_valid,
    output logic [rtop_pkg::ST_W-1:0]       o_status,
    output logic [rtop_pkg::VAL_W-1:0]      o_ranked_value,
    output logic [rtop_pkg::EVC_W-1:0]      o_evicted_total
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]                    r_state, n_state;
    logic [rtop_pkg::OP_W-1:0]     r_op;
    logic [rtop_pkg::AMT_W-1:0]    r_amt;
    logic [rtop_pkg::AMT_W-1:0]    r_min;
    rtop_pkg::t_key                r_key;
    rtop_pkg::t_key                r_adj;
    logic [CNT_W-1:0]              r_count;
    logic [rtop_pkg::EVC_W-1:0]    r_evicted, n_evicted;
    logic [rtop_pkg::ST_W-1:0]     r_status, n_status;
    logic                          r_found;
    rtop_pkg::t_key                r_sel;
    logic                          r_strobe;
    logic [rtop_pkg::ST_W-1:0]     r_out_status;
    logic [rtop_pkg::VAL_W-1:0]    r_out_value, n_out_value;
    logic [rtop_pkg::EVC_W-1:0]    r_out_evicted;

    logic                          w_accept;
    rtop_pkg::t_wide               w_adj_wide, w_amt_wide;
    logic                          w_below, w_full, w_do_ins, w_found;
    rtop_pkg::t_cmd                w_cmd;
    rtop_pkg::t_link               w_link [CAPACITY];
    rtop_pkg::t_key                w_rank_key [CAPACITY];
    logic [CNT_W-1:0]              w_bound [CAPACITY];
    logic [CAPACITY-1:0]           w_valid;
    rtop_pkg::t_key                w_rank_or;
    logic [CNT_W-1:0]              w_bound_or;
    logic [CNT_W-1:0]              w_removed;
    logic [rtop_pkg::EVC_W:0]      w_evc_sum;
    logic signed [rtop_pkg::KEY_W:0] w_cur;

    assign busy     = (r_state == S_EXEC);
    assign w_accept = start && !busy;

    assign w_adj_wide = {{2{r_adj[rtop_pkg::KEY_W-1]}}, r_adj};
    assign w_amt_wide = {{(rtop_pkg::WIDE_W - rtop_pkg::AMT_W){1'b0}}, i_amount};

    // decode in the execute cycle
    assign w_below  = (r_amt < r_min);
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_do_ins = (r_op == rtop_pkg::OP_INSERT) && !w_below && !w_full;
    assign w_found  = (r_amt != '0) && (r_amt <= rtop_pkg::AMT_W'(r_count));

    always_comb begin
        w_cmd.ins_en  = busy && w_do_ins;
        w_cmd.kill_en = busy && (r_op == rtop_pkg::OP_CUT);
        w_cmd.rank_en = busy && (r_op == rtop_pkg::OP_RANK);
        w_cmd.key     = r_key;
        w_cmd.thr     = $signed({{(rtop_pkg::WIDE_W - rtop_pkg::AMT_W){1'b0}}, r_min})
                        - w_adj_wide;
        w_cmd.rank    = r_amt;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        rtop_pkg::t_link w_left;
        logic            w_right_valid;
        if (g == 0) begin : g_head
            assign w_left = '{ge: 1'b1, valid: 1'b0, key: '0};
        end else begin : g_body
            assign w_left = w_link[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_right_valid = 1'b0;
        end else begin : g_mid
            assign w_right_valid = w_link[g+1].valid;
        end
        rtop_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_left        (w_left),
            .i_right_valid (w_right_valid),
            .o_link        (w_link[g]),
            .o_rank_key    (w_rank_key[g]),
            .o_bound       (w_bound[g])
        );
        assign w_valid[g] = w_link[g].valid;
    end

    always_comb begin
        w_rank_or  = '0;
        w_bound_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_rank_or  = w_rank_or | w_rank_key[i];
            w_bound_or = w_bound_or | w_bound[i];
        end
    end

    always_comb begin
        case (r_op)
            rtop_pkg::OP_INSERT: begin
                n_status = w_below ? rtop_pkg::ST_BELOW :
                           w_full  ? rtop_pkg::ST_FULL  : rtop_pkg::ST_DONE;
            end
            rtop_pkg::OP_RANK: begin
                n_status = w_found ? rtop_pkg::ST_VALID : rtop_pkg::ST_NOTFOUND;
            end
            default: begin
                n_status = rtop_pkg::ST_DONE;
            end
        endcase
    end

    // settle cycle: eviction total and reported value
    assign w_removed = r_count - w_bound_or;
    assign w_evc_sum = {1'b0, r_evicted} + (rtop_pkg::EVC_W + 1)'(w_removed);

    always_comb begin
        n_evicted = r_evicted;
        if (r_op == rtop_pkg::OP_CUT) begin
            n_evicted = w_evc_sum[rtop_pkg::EVC_W] ? '1 : w_evc_sum[rtop_pkg::EVC_W-1:0];
        end
    end

    assign w_cur = {r_sel[rtop_pkg::KEY_W-1], r_sel} + {r_adj[rtop_pkg::KEY_W-1], r_adj};

    always_comb begin
        if (!r_found || w_cur[rtop_pkg::KEY_W]) begin
            n_out_value = '0;
        end else if (w_cur[rtop_pkg::KEY_W-1]) begin
            n_out_value = '1;
        end else begin
            n_out_value = w_cur[rtop_pkg::VAL_W-1:0];
        end
    end

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = w_accept ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_FIN;
            S_FIN:   n_state = w_accept ? S_EXEC : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_min     <= '0;
            r_adj     <= '0;
            r_count   <= '0;
            r_evicted <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_FIN);
            if (i_cfg_we) begin
                r_min <= i_cfg_wdata;
            end
            if (w_accept && i_opcode == rtop_pkg::OP_RAISE) begin
                r_adj <= rtop_pkg::sat_key(w_adj_wide + w_amt_wide);
            end else if (w_accept && i_opcode == rtop_pkg::OP_CUT) begin
                r_adj <= rtop_pkg::sat_key(w_adj_wide - w_amt_wide);
            end
            if (busy && w_do_ins) begin
                r_count <= r_count + 1'b1;
            end else if (r_state == S_FIN && r_op == rtop_pkg::OP_CUT) begin
                r_count <= w_bound_or;
            end
            if (r_state == S_FIN) begin
                r_evicted <= n_evicted;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_opcode;
            r_amt <= i_amount;
            r_key <= rtop_pkg::sat_key(w_amt_wide - w_adj_wide);
        end
        if (busy) begin
            r_status <= n_status;
            r_found  <= w_found && (r_op == rtop_pkg::OP_RANK);
            r_sel    <= w_rank_or;
        end
        if (r_state == S_FIN) begin
            r_out_status  <= r_status;
            r_out_value   <= n_out_value;
            r_out_evicted <= n_evicted;
        end
    end

    assign o_valid         = r_strobe;
    assign o_status        = r_out_status;
    assign o_ranked_value  = r_out_value;
    assign o_evicted_total = r_out_evicted;

    a_exec_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("execute phase lasted more than one cycle");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> ##2 o_valid)
        else $error("no result beat two cycles after execute");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_chain_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid >> 1) & ~w_valid) == '0)
        else $error("hole in the cell chain");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(w_valid) == int'(r_count)))
        else $error("entry count disagrees with occupied cells");

endmodule

// ===== tb/tb_ranked_table_offset_prune.sv =====
`timescale 1ns / 1ps
// Self-checking bench for ranked_table_offset_prune: directed, random and
// large-offset beats checked against a scoreboard. Depends on rtop_pkg.
module tb_ranked_table_offset_prune;

    localparam int DEPTH = 64;
    localparam int PERIOD = 4;
    localparam int QUIET_LIMIT = 1000;
    localparam logic [rtop_pkg::AMT_W-1:0] AMT_MAX = '1;
    localparam rtop_pkg::t_key KEY_MAX = 32'sh7FFF_FFFF;
    localparam rtop_pkg::t_key KEY_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [rtop_pkg::ST_W-1:0]  status;
        logic [rtop_pkg::VAL_W-1:0] value;
        logic [rtop_pkg::EVC_W-1:0] evicted;
    } t_rank_result;

    class t_offset_table_sb #(int CAP = 64);
        rtop_pkg::t_key                 keys[CAP];
        int unsigned                    fill;
        rtop_pkg::t_key                 adjust;
        logic [rtop_pkg::EVC_W-1:0]     evicted;
        logic [rtop_pkg::AMT_W-1:0]     floor_level;
        t_rank_result                   expected_q[$];
        int                             fails;

        function new();
            fill = 0;
            adjust = '0;
            evicted = '0;
            floor_level = '0;
            fails = 0;
        endfunction

        function rtop_pkg::t_key clamp_key(longint x);
            if (x > longint'(KEY_MAX)) return KEY_MAX;
            if (x < longint'(KEY_MIN)) return KEY_MIN;
            return rtop_pkg::t_key'(x);
        endfunction

        function void note_beat(logic [rtop_pkg::OP_W-1:0] op,
                                logic [rtop_pkg::AMT_W-1:0] amt);
            t_rank_result r;
            rtop_pkg::t_key k;
            int unsigned pos;
            longint cur;
            longint gone;
            r.status = rtop_pkg::ST_DONE;
            r.value = '0;
            gone = 0;
            case (op)
                rtop_pkg::OP_INSERT: begin
                    if (amt < floor_level) begin
                        r.status = rtop_pkg::ST_BELOW;
                    end else if (fill >= CAP) begin
                        r.status = rtop_pkg::ST_FULL;
                    end else begin
                        k = clamp_key(longint'(amt) - longint'(adjust));
                        pos = 0;
                        while (pos < fill && keys[pos] >= k) pos++;
                        for (int unsigned i = fill; i > pos; i--) keys[i] = keys[i-1];
                        keys[pos] = k;
                        fill++;
                    end
                end
                rtop_pkg::OP_RAISE: begin
                    adjust = clamp_key(longint'(adjust) + longint'(amt));
                end
                rtop_pkg::OP_CUT: begin
                    adjust = clamp_key(longint'(adjust) - longint'(amt));
                    while (fill > 0 && longint'(keys[fill-1]) + longint'(adjust)
                           < longint'(floor_level)) begin
                        fill--;
                        gone++;
                    end
                    cur = longint'(evicted) + gone;
                    evicted = (cur > longint'(32'hFFFF_FFFF)) ? '1
                                                              : cur[rtop_pkg::EVC_W-1:0];
                end
                default: begin
                    if (amt == 0 || amt > fill) begin
                        r.status = rtop_pkg::ST_NOTFOUND;
                    end else begin
                        cur = longint'(keys[amt-1]) + longint'(adjust);
                        if (cur < 0) cur = 0;
                        if (cur > longint'(KEY_MAX)) cur = longint'(KEY_MAX);
                        r.value = cur[rtop_pkg::VAL_W-1:0];
                        r.status = rtop_pkg::ST_VALID;
                    end
                end
            endcase
            r.evicted = evicted;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [rtop_pkg::ST_W-1:0] st,
                                   logic [rtop_pkg::VAL_W-1:0] val,
                                   logic [rtop_pkg::EVC_W-1:0] evc);
            t_rank_result e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result status %0d value %0d evicted %0d",
                         $time, st, val, evc);
                fails++;
                return;
            end
            e = expected_q.pop_front();
            if (st !== e.status) begin
                $display("%0t: status expected %0d got %0d", $time, e.status, st);
                fails++;
            end
            if (val !== e.value) begin
                $display("%0t: ranked_value expected %0d got %0d", $time, e.value, val);
                fails++;
            end
            if (evc !== e.evicted) begin
                $display("%0t: evicted_total expected %0d got %0d", $time, e.evicted, evc);
                fails++;
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic [rtop_pkg::OP_W-1:0]      i_opcode;
    logic [rtop_pkg::AMT_W-1:0]     i_amount;
    logic                           i_cfg_we;
    logic [rtop_pkg::AMT_W-1:0]     i_cfg_wdata;
    logic                           o_valid;
    logic [rtop_pkg::ST_W-1:0]      o_status;
    logic [rtop_pkg::VAL_W-1:0]     o_ranked_value;
    logic [rtop_pkg::EVC_W-1:0]     o_evicted_total;

    t_offset_table_sb #(DEPTH) sb;
    int unsigned beats_in = 0;
    int unsigned quiet_cycles = 0;

    ranked_table_offset_prune #(
        .CAPACITY(DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_opcode(i_opcode),
        .i_amount(i_amount),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_valid(o_valid),
        .o_status(o_status),
        .o_ranked_value(o_ranked_value),
        .o_evicted_total(o_evicted_total)
    );

    always #(PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) sb.check_result(o_status, o_ranked_value, o_evicted_total);
            if (start && !busy) begin
                sb.note_beat(i_opcode, i_amount);
                beats_in <= beats_in + 1;
            end
            if (o_valid || (start && !busy)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == QUIET_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_beat(input logic [rtop_pkg::OP_W-1:0] op,
                             input logic [rtop_pkg::AMT_W-1:0] amt);
        int unsigned seen;
        seen = beats_in;
        start <= 1'b1;
        i_opcode <= op;
        i_amount <= amt;
        do @(negedge i_clk); while (beats_in == seen);
    endtask

    task automatic pause(input int n);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.expected_q.size() != 0 || busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_floor(input logic [rtop_pkg::AMT_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.floor_level = v;
    endtask

    function automatic logic [rtop_pkg::OP_W-1:0] pick_op(input int kind);
        int r;
        int ins_w;
        int rai_w;
        int cut_w;
        r = $urandom_range(0, 99);
        case (kind)
            0: begin ins_w = 80; rai_w = 5; cut_w = 5; end
            1: begin ins_w = 35; rai_w = 20; cut_w = 20; end
            2: begin ins_w = 25; rai_w = 10; cut_w = 40; end
            default: begin ins_w = 30; rai_w = 10; cut_w = 10; end
        endcase
        if (r < ins_w) return rtop_pkg::OP_INSERT;
        if (r < ins_w + rai_w) return rtop_pkg::OP_RAISE;
        if (r < ins_w + rai_w + cut_w) return rtop_pkg::OP_CUT;
        return rtop_pkg::OP_RANK;
    endfunction

    function automatic logic [rtop_pkg::AMT_W-1:0] pick_amount(
        input logic [rtop_pkg::OP_W-1:0] op);
        int r;
        int base;
        int v;
        r = $urandom_range(0, 99);
        base = int'(sb.floor_level);
        v = int'($urandom() & AMT_MAX);
        case (op)
            rtop_pkg::OP_INSERT: begin
                if (r < 50) v = base + $urandom_range(0, 4000);
                else if (r < 65) v = base - $urandom_range(1, 300);
                else if (r < 75) v = base + $urandom_range(0, 2);
            end
            rtop_pkg::OP_RAISE, rtop_pkg::OP_CUT: begin
                if (r < 88) v = $urandom_range(0, 3000);
                else if (r < 92) v = int'(AMT_MAX);
            end
            default: begin
                if (sb.fill > 0 && r < 70) v = $urandom_range(1, sb.fill);
                else if (r < 80) v = 0;
                else if (r < 90) v = sb.fill + $urandom_range(1, 3);
            end
        endcase
        if (v < 0) v = 0;
        if (v > int'(AMT_MAX)) v = int'(AMT_MAX);
        return v[rtop_pkg::AMT_W-1:0];
    endfunction

    initial begin
        logic [rtop_pkg::OP_W-1:0] op;
        logic [rtop_pkg::AMT_W-1:0] floor_v;
        sb = new();
        i_rst_n = 1'b0;
        start = 1'b0;
        i_opcode = rtop_pkg::OP_INSERT;
        i_amount = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty table, extremes, equal values, offset round trip
        set_floor('0);
        send_beat(rtop_pkg::OP_RANK, 0);
        send_beat(rtop_pkg::OP_RANK, 1);
        send_beat(rtop_pkg::OP_CUT, 0);
        send_beat(rtop_pkg::OP_INSERT, 0);
        send_beat(rtop_pkg::OP_INSERT, AMT_MAX);
        send_beat(rtop_pkg::OP_INSERT, 500);
        send_beat(rtop_pkg::OP_INSERT, 500);
        send_beat(rtop_pkg::OP_INSERT, 1);
        send_beat(rtop_pkg::OP_RANK, 1);
        send_beat(rtop_pkg::OP_RANK, 3);
        send_beat(rtop_pkg::OP_RANK, 5);
        send_beat(rtop_pkg::OP_RANK, 6);
        send_beat(rtop_pkg::OP_RANK, AMT_MAX);
        send_beat(rtop_pkg::OP_RAISE, AMT_MAX);
        send_beat(rtop_pkg::OP_RANK, 1);
        send_beat(rtop_pkg::OP_CUT, AMT_MAX);
        send_beat(rtop_pkg::OP_CUT, 600);
        send_beat(rtop_pkg::OP_RANK, 1);
        drain();
        set_floor(1000);
        send_beat(rtop_pkg::OP_INSERT, 999);
        send_beat(rtop_pkg::OP_INSERT, 1000);
        send_beat(rtop_pkg::OP_RANK, 2);
        // raising the floor keeps stale entries until the next cut
        drain();
        set_floor(AMT_MAX);
        send_beat(rtop_pkg::OP_RANK, 2);
        send_beat(rtop_pkg::OP_INSERT, AMT_MAX - 1'b1);
        send_beat(rtop_pkg::OP_CUT, 0);
        send_beat(rtop_pkg::OP_RANK, 1);

        for (int phase = 0; phase < 12; phase++) begin
            drain();
            case (phase % 4)
                0: floor_v = rtop_pkg::AMT_W'($urandom_range(0, 50));
                1: floor_v = rtop_pkg::AMT_W'($urandom_range(0, AMT_MAX));
                2: floor_v = rtop_pkg::AMT_W'($urandom_range(AMT_MAX - 20000, AMT_MAX));
                default: floor_v = rtop_pkg::AMT_W'($urandom_range(0, 5000));
            endcase
            if (phase == 0) floor_v = '0;
            if (phase == 11) floor_v = AMT_MAX;
            set_floor(floor_v);
            for (int i = 0; i < 150; i++) begin
                op = pick_op(phase % 4);
                if (phase != 11 && phase % 3 != 2 && $urandom_range(0, 4) == 0)
                    pause($urandom_range(1, 10));
                send_beat(op, pick_amount(op));
            end
        end

        // push the offset far from zero in both directions
        drain();
        set_floor('0);
        send_beat(rtop_pkg::OP_INSERT, AMT_MAX);
        send_beat(rtop_pkg::OP_INSERT, 5);
        send_beat(rtop_pkg::OP_RANK, 1);
        repeat (10) send_beat(rtop_pkg::OP_RAISE, AMT_MAX);
        send_beat(rtop_pkg::OP_RAISE, 1);
        send_beat(rtop_pkg::OP_RANK, 1);
        send_beat(rtop_pkg::OP_RANK, 2);
        send_beat(rtop_pkg::OP_INSERT, 0);
        send_beat(rtop_pkg::OP_RANK, 3);
        repeat (20) send_beat(rtop_pkg::OP_CUT, AMT_MAX);
        send_beat(rtop_pkg::OP_CUT, 5);
        send_beat(rtop_pkg::OP_INSERT, AMT_MAX);
        send_beat(rtop_pkg::OP_INSERT, 0);
        send_beat(rtop_pkg::OP_RANK, 1);
        send_beat(rtop_pkg::OP_RANK, 2);
        send_beat(rtop_pkg::OP_CUT, 0);
        send_beat(rtop_pkg::OP_RANK, 1);
        send_beat(rtop_pkg::OP_RAISE, 7);
        send_beat(rtop_pkg::OP_RANK, 1);

        drain();
        repeat (8) @(negedge i_clk);
        if (sb.expected_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, sb.expected_q.size());
            sb.fails++;
        end
        if (sb.fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== ranked_table_offset_prune.f =====
sv/rtop_pkg.sv
sv/rtop_cell.sv
sv/ranked_table_offset_prune.sv
tb/tb_ranked_table_offset_prune.sv
